// File: src/byte_mode_check_core_defines.svh
// ---------------------------------------------------------------------------
// Byte mode check assertion macros
// Shared assertion forms for the byte mode check block.
// ---------------------------------------------------------------------------
`ifndef BYTE_MODE_CHECK_CORE_DEFINES_SVH
`define BYTE_MODE_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/bmc_pkg.sv
// ---------------------------------------------------------------------------
// Byte mode check package
// Constants, controller states, command and status types, count helpers.
// ---------------------------------------------------------------------------
package bmc_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int HIST_DEPTH  = 256;
	localparam int IDX_W       = $clog2(HIST_DEPTH);
	localparam int BYTE_W      = 8;
	localparam int RESULT_W    = 32;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [IDX_W-1:0]       idx_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_UPD   = 6'b000010,
		S_TREAD = 6'b000100,
		S_TCAP  = 6'b001000,
		S_SCAN  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	typedef struct packed {
		logic accept_rd;
		logic upd_we;
		logic tgt_rd;
		logic tc_cap;
		logic scan_rd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic scan_done;
		logic out_free;
	} sts_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + COUNT_WIDTH'(1);
	endfunction

	function automatic logic [RESULT_W-1:0] clip_result(input count_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[RESULT_W-1:0];
	endfunction

endpackage

// File: src/byte_mode_check_core.sv
// ---------------------------------------------------------------------------
// Byte mode check core
// Bytes enter on the input channel (in_valid, in_stall, data_byte,
// last_byte). Each item adds one to that value's saturating counter.
// After the item marked last_byte, one result (verdict, target_count)
// leaves on the output channel; verdict is 0 when no other value is
// strictly more frequent than the target, which cfg_data sets; the user
// must set it only while idle; the block does not enforce this. A byte is
// a read and then a write of the histogram memory; the last byte of a
// stream adds a scan of all 256 entries through the single read port.
// The result waits in an output register while out_stall is high; new
// bytes are taken meanwhile, but the next result waits for the slot.
// Reset clears the target, the state and the per-entry valid bits,
// which also clear at once after every stream; there is no clearing pass.
// ---------------------------------------------------------------------------
`include "byte_mode_check_core_defines.svh"

module byte_mode_check_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bmc_pkg::BYTE_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bmc_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         last_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         verdict,
	output logic [bmc_pkg::RESULT_W-1:0] target_count
);

	bmc_pkg::cmd_t cmd;
	bmc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	bmc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	bmc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.verdict     (verdict),
		.target_count(target_count)
	);

	`BMC_ASSERT_NOW(a_load_slot_free, cmd.load_out, !(out_valid && out_stall), "slot busy")
	`BMC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy")
	`BMC_ASSERT_NOW(a_no_write_in_scan, cmd.upd_we, !cmd.scan_rd && !cmd.accept_rd, "write on read")

endmodule

// File: src/bmc_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/bmc_ctrl.sv
// ---------------------------------------------------------------------------
// Byte mode check controller
// Sequences counter updates, the end-of-stream scan and the result load.
// ---------------------------------------------------------------------------
module bmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bmc_pkg::sts_t sts,
	output bmc_pkg::cmd_t cmd
);

	bmc_pkg::state_t state_q;
	bmc_pkg::state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			bmc_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.accept_rd = 1'b1;
					state_d       = bmc_pkg::S_UPD;
				end
			end
			bmc_pkg::S_UPD: begin
				cmd.upd_we = 1'b1;
				state_d    = sts.last ? bmc_pkg::S_TREAD : bmc_pkg::S_IDLE;
			end
			bmc_pkg::S_TREAD: begin
				cmd.tgt_rd = 1'b1;
				state_d    = bmc_pkg::S_TCAP;
			end
			bmc_pkg::S_TCAP: begin
				cmd.tc_cap  = 1'b1;
				cmd.scan_rd = 1'b1;
				state_d     = bmc_pkg::S_SCAN;
			end
			bmc_pkg::S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_done) begin
					state_d = bmc_pkg::S_FIN;
				end
			end
			bmc_pkg::S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = bmc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bmc_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != bmc_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/bmc_dpath.sv
// ---------------------------------------------------------------------------
// Byte mode check datapath
// Histogram memory with valid bits, saturating update, scan compare, result.
// ---------------------------------------------------------------------------
module bmc_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bmc_pkg::cmd_t                cmd,
	output bmc_pkg::sts_t                sts,
	input  logic [bmc_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         last_byte,
	input  logic                         cfg_valid,
	input  logic [bmc_pkg::BYTE_W-1:0]   cfg_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         verdict,
	output logic [bmc_pkg::RESULT_W-1:0] target_count
);

	logic [bmc_pkg::HIST_DEPTH-1:0] valid_q;
	logic [bmc_pkg::BYTE_W-1:0]     target_q;
	bmc_pkg::idx_t                  byte_s1;
	logic                           last_s1;
	bmc_pkg::idx_t                  raddr;
	bmc_pkg::count_t                rdata;
	bmc_pkg::count_t                eff_rdata;
	bmc_pkg::count_t                wdata;
	logic                           rd_vld_s1;
	bmc_pkg::idx_t                  rd_idx_s1;
	logic                           cmp_en_s1;
	logic                           scan_issue;
	logic [bmc_pkg::IDX_W:0]        scan_cnt_q;
	bmc_pkg::count_t                tc_q;
	logic                           verdict_q;
	logic                           out_valid_q;
	logic                           out_verdict_q;
	logic [bmc_pkg::RESULT_W-1:0]   out_count_q;

	assign scan_issue = cmd.scan_rd && !scan_cnt_q[bmc_pkg::IDX_W];

	always_comb begin
		raddr = scan_cnt_q[bmc_pkg::IDX_W-1:0];
		if (cmd.accept_rd) begin
			raddr = data_byte;
		end else if (cmd.tgt_rd) begin
			raddr = target_q;
		end
	end

	bmc_ram #(
		.WIDTH(bmc_pkg::COUNT_WIDTH),
		.DEPTH(bmc_pkg::HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (cmd.upd_we),
		.waddr(byte_s1),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Entries not written since the last clear read as zero.
	assign eff_rdata = rd_vld_s1 ? rdata : '0;
	assign wdata     = bmc_pkg::sat_inc(eff_rdata);

	always_ff @(posedge clk) begin
		rd_idx_s1 <= raddr;
		if (cmd.accept_rd) begin
			byte_s1 <= data_byte;
		end
		if (cmd.tc_cap) begin
			tc_q <= eff_rdata;
		end
		if (cmd.load_out) begin
			out_verdict_q <= verdict_q;
			out_count_q   <= bmc_pkg::clip_result(tc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			target_q    <= '0;
			last_s1     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			cmp_en_s1   <= 1'b0;
			scan_cnt_q  <= '0;
			verdict_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= valid_q[raddr];
			cmp_en_s1 <= scan_issue;
			if (cfg_valid) begin
				target_q <= cfg_data;
			end
			if (cmd.accept_rd) begin
				last_s1 <= last_byte;
			end
			if (cmd.load_out) begin
				valid_q <= '0;
			end else if (cmd.upd_we) begin
				valid_q[byte_s1] <= 1'b1;
			end
			if (cmd.tgt_rd) begin
				scan_cnt_q <= '0;
				verdict_q  <= 1'b0;
			end else begin
				if (scan_issue) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
				if (cmp_en_s1 && (rd_idx_s1 != target_q) && (eff_rdata > tc_q)) begin
					verdict_q <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts = '{
		last:      last_s1,
		scan_done: scan_cnt_q[bmc_pkg::IDX_W],
		out_free:  !out_valid_q || !out_stall
	};

	assign out_valid    = out_valid_q;
	assign verdict      = out_verdict_q;
	assign target_count = out_count_q;

endmodule
